@@ sv/fpc_pkg.sv @@
// shared types and constants of the frustum point culler
package fpc_pkg;

  localparam int CoordBits  = 20;
  localparam int FracBits   = 10;
  localparam int FarBits    = 19;
  localparam int CfgBits    = 3 * CoordBits;
  localparam int CfgIdxBits = 3;
  localparam int NrmBits    = 34;
  localparam int OpBits     = CoordBits + 2;
  localparam int MulBits    = NrmBits + OpBits;
  localparam int AccBits    = 48;
  localparam int RootBits   = CoordBits;
  localparam int SqBits     = 2 * RootBits;
  localparam int RemBits    = RootBits + 2;
  localparam int NumBits    = CoordBits + FarBits;
  localparam int IterBits   = 6;

  localparam logic [CfgIdxBits-1:0] CfgRayOne   = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgRayTwo   = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgRayThree = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgRayFour  = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgEye      = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgFar      = 3'd5;
  localparam logic [FarBits-1:0]    FarReset    = 19'd102400;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [NrmBits-1:0]   nrm_t;
  typedef logic signed [AccBits-1:0]   acc_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    coord_t normal_x;
    coord_t normal_y;
    coord_t normal_z;
    logic   last_point;
  } in_item_t;

  typedef struct packed {
    logic   inside_res;
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    coord_t out_normal_x;
    coord_t out_normal_y;
    coord_t out_normal_z;
    logic   set_end;
  } out_item_t;

  typedef struct {
    nrm_t nrm [6][3];
    acc_t off [6];
  } planes_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gen_status_t;

endpackage

@@ sv/fpc_in_if.sv @@
// input point channel
interface fpc_in_if;
  logic               valid;
  logic               ready;
  fpc_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/fpc_out_if.sv @@
// result channel
interface fpc_out_if;
  logic               valid;
  logic               ready;
  fpc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/fpc_plane_gen.sv @@
// sequential derivation of the six frustum planes
module fpc_plane_gen (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  fpc_pkg::coord_t                   ray_i [4][3],
  input  fpc_pkg::coord_t                   eye_i [3],
  input  logic [fpc_pkg::FarBits-1:0]       far_i,
  output fpc_pkg::gen_status_t              status_o,
  output fpc_pkg::planes_t                  planes_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSq    = 3'd1;
  localparam logic [2:0] StRoot  = 3'd2;
  localparam logic [2:0] StDivL  = 3'd3;
  localparam logic [2:0] StDiv   = 3'd4;
  localparam logic [2:0] StCross = 3'd5;
  localparam logic [2:0] StDot   = 3'd6;

  logic [2:0]                          state_q;
  logic [2:0]                          k_q;
  logic [1:0]                          c_q;
  logic [1:0]                          t_q;
  logic [fpc_pkg::IterBits-1:0]        it_q;
  logic                                done_q;
  logic                                far_ok_q;
  logic signed [fpc_pkg::MulBits-1:0]  prod_q;
  logic                                neg_q;
  fpc_pkg::acc_t                       acc_q;
  logic [fpc_pkg::SqBits-1:0]          sq_q;
  logic [fpc_pkg::RemBits-1:0]         rem_q;
  logic [fpc_pkg::RootBits-1:0]        root_q;
  logic [fpc_pkg::RootBits-1:0]        len_q;
  logic [fpc_pkg::NumBits-1:0]         num_q;
  logic [fpc_pkg::RootBits-1:0]        drem_q;
  logic [fpc_pkg::CoordBits-1:0]       quo_q;
  fpc_pkg::coord_t                     f_q [3][3];
  fpc_pkg::nrm_t                       nrm_q [6][3];
  fpc_pkg::acc_t                       off_q [6];

  logic [1:0]                          c1, c2, tc;
  logic [1:0]                          ra, rb;
  logic signed [fpc_pkg::OpBits-1:0]   a_v [3];
  logic signed [fpc_pkg::OpBits-1:0]   b_v [3];
  logic signed [fpc_pkg::OpBits-1:0]   pt_v [3];
  logic signed [fpc_pkg::NrmBits-1:0]  x_op;
  logic signed [fpc_pkg::OpBits-1:0]   y_op;
  logic                                neg_d;
  logic signed [fpc_pkg::MulBits-1:0]  prod_d;
  logic signed [fpc_pkg::MulBits-1:0]  prod_sh;
  fpc_pkg::acc_t                       term, sterm, fin;
  logic [1:0]                          n_terms;
  logic [fpc_pkg::RemBits+1:0]         rem_cat, trial;
  logic                                root_ge;
  logic [fpc_pkg::RootBits-1:0]        root_nx;
  logic [fpc_pkg::RootBits:0]          dr;
  logic                                div_ge;
  logic [fpc_pkg::CoordBits-1:0]       quo_nx;
  fpc_pkg::coord_t                     ray_kc;
  logic [fpc_pkg::CoordBits-1:0]       mag_kc;
  logic [fpc_pkg::NumBits-1:0]         num_d;

  always_comb begin
    c1 = (c_q == 2'd0) ? 2'd1 : ((c_q == 2'd1) ? 2'd2 : 2'd0);
    c2 = (c_q == 2'd0) ? 2'd2 : ((c_q == 2'd1) ? 2'd0 : 2'd1);
    tc = (t_q == 2'd3) ? 2'd0 : t_q;
    ra = k_q[1:0] + 2'd2;
    rb = k_q[1:0] + 2'd3;
    for (int i = 0; i < 3; i++) begin
      unique case (k_q)
        3'd0: begin
          a_v[i] = fpc_pkg::OpBits'(f_q[0][i]) - fpc_pkg::OpBits'(f_q[1][i]);
          b_v[i] = fpc_pkg::OpBits'(f_q[2][i]) - fpc_pkg::OpBits'(f_q[1][i]);
          pt_v[i] = fpc_pkg::OpBits'(eye_i[i]) + fpc_pkg::OpBits'(f_q[0][i]);
        end
        3'd1: begin
          a_v[i] = fpc_pkg::OpBits'(ray_i[2][i]) - fpc_pkg::OpBits'(ray_i[1][i]);
          b_v[i] = fpc_pkg::OpBits'(ray_i[0][i]) - fpc_pkg::OpBits'(ray_i[1][i]);
          pt_v[i] = fpc_pkg::OpBits'(eye_i[i]) + fpc_pkg::OpBits'(ray_i[3][i]);
        end
        default: begin
          a_v[i] = fpc_pkg::OpBits'(ray_i[ra][i]);
          b_v[i] = fpc_pkg::OpBits'(ray_i[rb][i]);
          pt_v[i] = fpc_pkg::OpBits'(eye_i[i]);
        end
      endcase
    end
    unique case (state_q)
      StCross: begin
        x_op    = fpc_pkg::NrmBits'((t_q == 2'd0) ? a_v[c1] : a_v[c2]);
        y_op    = (t_q == 2'd0) ? b_v[c2] : b_v[c1];
        neg_d   = (t_q != 2'd0);
        n_terms = 2'd2;
      end
      StDot: begin
        x_op    = nrm_q[k_q][tc];
        y_op    = pt_v[tc];
        neg_d   = 1'b1;
        n_terms = 2'd3;
      end
      default: begin
        x_op    = fpc_pkg::NrmBits'(ray_i[k_q[1:0]][tc]);
        y_op    = fpc_pkg::OpBits'(ray_i[k_q[1:0]][tc]);
        neg_d   = 1'b0;
        n_terms = 2'd3;
      end
    endcase
    prod_d  = x_op * y_op;
    prod_sh = (state_q == StSq) ? prod_q : (prod_q >>> fpc_pkg::FracBits);
    term    = fpc_pkg::AccBits'(prod_sh);
    sterm   = neg_q ? -term : term;
    fin     = acc_q + sterm;

    rem_cat = {rem_q, sq_q[fpc_pkg::SqBits-1 -: 2]};
    trial   = {2'b00, root_q, 2'b01};
    root_ge = (rem_cat >= trial);
    root_nx = {root_q[fpc_pkg::RootBits-2:0], root_ge};

    dr      = {drem_q, num_q[fpc_pkg::NumBits-1]};
    div_ge  = (dr >= {1'b0, len_q});
    quo_nx  = {quo_q[fpc_pkg::CoordBits-2:0], div_ge};

    ray_kc  = ray_i[k_q[1:0]][c_q];
    mag_kc  = ray_kc[fpc_pkg::CoordBits-1] ? (~ray_kc + 1'b1) : ray_kc;
    num_d   = fpc_pkg::NumBits'(mag_kc) * fpc_pkg::NumBits'(far_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      k_q     <= '0;
      c_q     <= '0;
      t_q     <= '0;
      it_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            state_q <= StSq;
            k_q     <= '0;
            c_q     <= '0;
            t_q     <= '0;
          end
        end
        StSq, StCross, StDot: begin
          if (t_q == n_terms) begin
            t_q <= '0;
            if (state_q == StSq) begin
              state_q <= StRoot;
              it_q    <= '0;
            end else if (c_q != 2'd2) begin
              c_q <= c_q + 2'd1;
            end else if (k_q != 3'd5) begin
              c_q <= '0;
              k_q <= k_q + 3'd1;
            end else if (state_q == StCross) begin
              state_q <= StDot;
              c_q     <= '0;
              k_q     <= '0;
            end else begin
              state_q <= StIdle;
              done_q  <= 1'b1;
            end
          end else begin
            t_q <= t_q + 2'd1;
          end
        end
        StRoot: begin
          it_q <= it_q + 1'b1;
          if (it_q == fpc_pkg::IterBits'(fpc_pkg::RootBits - 1)) begin
            c_q <= '0;
            if (root_nx != '0) begin
              state_q <= StDivL;
            end else if (k_q != 3'd2) begin
              state_q <= StSq;
              k_q     <= k_q + 3'd1;
            end else begin
              state_q <= StCross;
              k_q     <= '0;
            end
          end
        end
        StDivL: begin
          state_q <= StDiv;
          it_q    <= '0;
        end
        StDiv: begin
          it_q <= it_q + 1'b1;
          if (it_q == fpc_pkg::IterBits'(fpc_pkg::NumBits - 1)) begin
            if (c_q != 2'd2) begin
              state_q <= StDivL;
              c_q     <= c_q + 2'd1;
            end else if (k_q != 3'd2) begin
              state_q <= StSq;
              c_q     <= '0;
              k_q     <= k_q + 3'd1;
            end else begin
              state_q <= StCross;
              c_q     <= '0;
              k_q     <= '0;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        far_ok_q <= 1'b1;
      end
      StSq, StCross, StDot: begin
        prod_q <= prod_d;
        neg_q  <= neg_d;
        if (t_q == 2'd1) begin
          acc_q <= sterm;
        end else if (t_q == 2'd2) begin
          acc_q <= fin;
        end
        if (t_q == n_terms) begin
          if (state_q == StSq) begin
            sq_q   <= fin[fpc_pkg::SqBits-1:0];
            rem_q  <= '0;
            root_q <= '0;
          end else if (state_q == StCross) begin
            nrm_q[k_q][c_q] <= (k_q == 3'd0 && !far_ok_q) ? '0 :
                               fin[fpc_pkg::NrmBits-1:0];
          end else begin
            off_q[k_q] <= fin;
          end
        end
      end
      StRoot: begin
        sq_q   <= {sq_q[fpc_pkg::SqBits-3:0], 2'b00};
        rem_q  <= root_ge ? fpc_pkg::RemBits'(rem_cat - trial) :
                            fpc_pkg::RemBits'(rem_cat);
        root_q <= root_nx;
        if (it_q == fpc_pkg::IterBits'(fpc_pkg::RootBits - 1)) begin
          len_q <= root_nx;
          if (root_nx == '0) begin
            far_ok_q <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              f_q[k_q[1:0]][i] <= '0;
            end
          end
        end
      end
      StDivL: begin
        num_q  <= num_d;
        drem_q <= '0;
        quo_q  <= '0;
      end
      StDiv: begin
        num_q  <= {num_q[fpc_pkg::NumBits-2:0], 1'b0};
        drem_q <= div_ge ? fpc_pkg::RootBits'(dr - {1'b0, len_q}) :
                           fpc_pkg::RootBits'(dr);
        quo_q  <= quo_nx;
        if (it_q == fpc_pkg::IterBits'(fpc_pkg::NumBits - 1)) begin
          f_q[k_q[1:0]][c_q] <= ray_kc[fpc_pkg::CoordBits-1] ? -quo_nx : quo_nx;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status_o.busy = (state_q != StIdle);
    status_o.done = done_q;
    planes_o.nrm  = nrm_q;
    planes_o.off  = off_q;
  end

endmodule

@@ sv/fpc_test_pipe.sv @@
// pipelined six-plane test of one point per cycle while enabled
module fpc_test_pipe (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  fpc_pkg::in_item_t    item_i,
  input  fpc_pkg::planes_t     planes_i,
  output logic                 busy_o,
  output logic                 valid_o,
  output fpc_pkg::out_item_t   item_o
);

  localparam int PBits = fpc_pkg::NrmBits + fpc_pkg::CoordBits;

  logic                  v1_q, v2_q, v3_q, vo_q;
  fpc_pkg::in_item_t     it1_q, it2_q, it3_q;
  fpc_pkg::out_item_t    oi_q;
  fpc_pkg::acc_t         pr_q [6][3];
  logic [5:0]            gt_q;

  fpc_pkg::coord_t       pt [3];
  logic signed [PBits-1:0] pr_d [6][3];
  fpc_pkg::acc_t         plane_dist [6];

  always_comb begin
    pt[0] = it1_q.point_x;
    pt[1] = it1_q.point_y;
    pt[2] = it1_q.point_z;
    for (int p = 0; p < 6; p++) begin
      for (int i = 0; i < 3; i++) begin
        pr_d[p][i] = planes_i.nrm[p][i] * pt[i];
      end
      plane_dist[p] = pr_q[p][0] + pr_q[p][1] + pr_q[p][2] + planes_i.off[p];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it1_q <= item_i;
      it2_q <= it1_q;
      it3_q <= it2_q;
      for (int p = 0; p < 6; p++) begin
        for (int i = 0; i < 3; i++) begin
          pr_q[p][i] <= fpc_pkg::AccBits'(pr_d[p][i] >>> fpc_pkg::FracBits);
        end
        gt_q[p] <= !plane_dist[p][fpc_pkg::AccBits-1] && (plane_dist[p] != '0);
      end
      oi_q.inside_res   <= ~|gt_q;
      oi_q.out_x        <= it3_q.point_x;
      oi_q.out_y        <= it3_q.point_y;
      oi_q.out_z        <= it3_q.point_z;
      oi_q.out_normal_x <= it3_q.normal_x;
      oi_q.out_normal_y <= it3_q.normal_y;
      oi_q.out_normal_z <= it3_q.normal_z;
      oi_q.set_end      <= it3_q.last_point;
    end
  end

  assign busy_o  = v1_q | v2_q | v3_q;
  assign valid_o = vo_q;
  assign item_o  = oi_q;

endmodule

@@ sv/frustum_point_culler_core.sv @@
// top level: frustum point culler with configuration registers
// pipeline: a point passes input, product, plane-sign and output registers before its result is offered
// throughput: one point per cycle while the result side takes one per cycle
// the first point of a set waits for plane derivation, carried out by
// the shared multiply-accumulate unit and the bit-serial root and divide
// reset: asynchronous active low; registers to defaults, planes marked stale
module frustum_point_culler_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fpc_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [fpc_pkg::CfgBits-1:0]       cfg_wdata_i,
  fpc_in_if.sink                            in_if,
  fpc_out_if.source                         out_if
);

  logic [fpc_pkg::CfgBits-1:0]  ray_q [5];
  logic [fpc_pkg::FarBits-1:0]  far_q;
  logic                         planes_valid_q;

  fpc_pkg::coord_t              ray [4][3];
  fpc_pkg::coord_t              eye [3];
  fpc_pkg::gen_status_t         gen_status;
  fpc_pkg::planes_t             planes;
  logic                         en, pipe_busy, gen_start, in_acc;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 4; k++) begin
        ray[k][i] = ray_q[k][i*fpc_pkg::CoordBits +: fpc_pkg::CoordBits];
      end
      eye[i] = ray_q[4][i*fpc_pkg::CoordBits +: fpc_pkg::CoordBits];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 5; k++) begin
        ray_q[k] <= '0;
      end
      far_q <= fpc_pkg::FarReset;
    end else if (cfg_we_i) begin
      priority if (cfg_idx_i == fpc_pkg::CfgFar) begin
        far_q <= cfg_wdata_i[fpc_pkg::FarBits-1:0];
      end else if (cfg_idx_i <= fpc_pkg::CfgEye) begin
        ray_q[cfg_idx_i] <= cfg_wdata_i;
      end
    end
  end

  assign en        = !out_if.valid || out_if.ready;
  assign in_if.ready = en && planes_valid_q;
  assign in_acc    = in_if.valid && in_if.ready;
  assign gen_start = in_if.valid && !planes_valid_q && !gen_status.busy &&
                     !gen_status.done && !pipe_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      planes_valid_q <= 1'b0;
    end else if (gen_status.done) begin
      planes_valid_q <= 1'b1;
    end else if (in_acc && in_if.data.last_point) begin
      planes_valid_q <= 1'b0;
    end
  end

  fpc_plane_gen u_gen (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (gen_start),
    .ray_i    (ray),
    .eye_i    (eye),
    .far_i    (far_q),
    .status_o (gen_status),
    .planes_o (planes)
  );

  fpc_test_pipe u_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_acc),
    .item_i   (in_if.data),
    .planes_i (planes),
    .busy_o   (pipe_busy),
    .valid_o  (out_if.valid),
    .item_o   (out_if.data)
  );

  a_accept_needs_planes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> planes_valid_q)
    else $error("point transaction taken without valid planes");

  a_start_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_start |-> !pipe_busy && !planes_valid_q)
    else $error("plane derivation started with points in flight");

  a_done_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_status.done |=> planes_valid_q)
    else $error("planes not marked valid after derivation");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |-> !in_if.ready)
    else $error("input taken while result stalled");

endmodule
